// File: hw/rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared constants, the command passed from front to back, and back states.
// ----------------------------------------------------------------------------
`default_nettype none
package lzwd_pkg;

  localparam int unsigned LITERALS    = 256;
  localparam int unsigned STACK_DEPTH = 257;
  localparam int unsigned CODE_W      = 9;
  localparam int unsigned STACK_AW    = 9;
  localparam logic [7:0]  BYTE_MASK   = 8'hff;

  typedef struct packed {
    logic              err;
    logic              pre_wr;
    logic              post_wr;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] parent;
    logic [7:0]        wr_idx;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_ISSUE,
    ST_WALK,
    ST_LIT,
    ST_RD,
    ST_AP,
    ST_OUT,
    ST_ERR
  } back_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/lzwd_front.sv
// ----------------------------------------------------------------------------
// LZW decoder front end
// Accepts codes, tracks the next free code and classifies each code.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwd_front #(
  parameter int DICT_CODES = 512,
  parameter int NW         = 10,
  parameter int CAP        = 512
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [lzwd_pkg::CODE_W-1:0] in_code,
  input  wire logic                        in_restart,
  output logic                             cmd_push,
  output lzwd_pkg::cmd_t                   cmd_data,
  input  wire logic                        cmd_full
);

  localparam logic [NW-1:0] LIT_BASE = NW'(lzwd_pkg::LITERALS);
  localparam logic [NW-1:0] DICT_LIM = NW'(DICT_CODES);
  localparam logic [NW-1:0] CAP_LIM  = NW'(CAP);

  logic [NW-1:0]               nfc_r, nfc_nxt, nfc_eff;
  logic                        have_prev_r, have_prev_nxt, hp;
  logic [lzwd_pkg::CODE_W-1:0] prev_code_r, prev_code_nxt;
  logic [NW-1:0]               code_ext;
  logic                        accept;

  assign full     = cmd_full;
  assign accept   = push && !cmd_full;
  assign cmd_push = accept;
  assign code_ext = NW'(in_code);
  assign nfc_eff  = in_restart ? LIT_BASE : nfc_r;
  assign hp       = have_prev_r && !in_restart;

  always_comb begin
    cmd_data         = '0;
    cmd_data.code    = in_code;
    cmd_data.parent  = prev_code_r;
    cmd_data.wr_idx  = nfc_eff[7:0];
    nfc_nxt          = nfc_eff;
    have_prev_nxt    = hp;
    prev_code_nxt    = prev_code_r;
    if (!hp) begin
      if (code_ext >= LIT_BASE) begin
        cmd_data.err = 1'b1;
      end else begin
        have_prev_nxt = 1'b1;
        prev_code_nxt = in_code;
      end
    end else if (code_ext < nfc_eff) begin
      cmd_data.post_wr = nfc_eff < CAP_LIM;
      if (nfc_eff < DICT_LIM) begin
        nfc_nxt = nfc_eff + NW'(1);
      end
      prev_code_nxt = in_code;
    end else if (code_ext == nfc_eff && nfc_eff < DICT_LIM) begin
      cmd_data.pre_wr = 1'b1;
      nfc_nxt         = nfc_eff + NW'(1);
      prev_code_nxt   = in_code;
    end else begin
      cmd_data.err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfc_r       <= LIT_BASE;
      have_prev_r <= 1'b0;
      prev_code_r <= '0;
    end else if (accept) begin
      nfc_r       <= nfc_nxt;
      have_prev_r <= have_prev_nxt;
      prev_code_r <= prev_code_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lzwd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// LZW decoder command queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwd_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  lzwd_pkg::cmd_t      wr_data,
  output logic                fifo_full,
  input  wire logic           rd_en,
  output lzwd_pkg::cmd_t      rd_data,
  output logic                fifo_empty
);

  lzwd_pkg::cmd_t slot_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign fifo_full  = cnt_r == 2'd2;
  assign fifo_empty = cnt_r == 2'd0;
  assign rd_data    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !fifo_full) begin
      slot_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en && !fifo_full) begin
        wp_r <= !wp_r;
      end
      if (rd_en && !fifo_empty) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'((wr_en && !fifo_full) ? 1 : 0) - 2'((rd_en && !fifo_empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lzwd_back.sv
// ----------------------------------------------------------------------------
// LZW decoder back end
// Walks the dictionary chain onto a byte stack and packs the string.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwd_back #(
  parameter int STORE = 256,
  parameter int IW    = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  lzwd_pkg::cmd_t      cmd_data,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [63:0]         out_bytes_out,
  output logic [3:0]          out_byte_count,
  output logic                out_last,
  output logic                out_bad_code
);

  localparam int unsigned SAW = lzwd_pkg::STACK_AW;

  lzwd_pkg::back_state_t state_r, state_nxt;
  lzwd_pkg::cmd_t        cmd_r, cmd_nxt;

  logic [lzwd_pkg::CODE_W-1:0] parent_mem [STORE];
  logic [7:0]                  suffix_mem [STORE];
  logic [7:0]                  stack_mem  [lzwd_pkg::STACK_DEPTH];

  logic [lzwd_pkg::CODE_W-1:0] parent_q;
  logic [7:0]                  suffix_q, stack_q;
  logic [IW-1:0]               dict_rd_addr, dict_wr_addr;
  logic                        dict_wr;
  logic [lzwd_pkg::CODE_W-1:0] dict_wr_parent;
  logic [7:0]                  dict_wr_byte;
  logic                        stack_wr;
  logic [7:0]                  stack_wr_byte;
  logic [SAW-1:0]              stack_rd_addr;

  logic [SAW-1:0] n_r, n_nxt, sp_r, sp_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [63:0]    asm_r, asm_nxt;
  logic [7:0]     lit_r, lit_nxt, prev_first_r, prev_first_nxt;
  logic           out_free, out_load, out_bad_in, out_last_in;
  logic           out_valid_r;
  logic [63:0]    out_bytes_r;
  logic [3:0]     out_count_r;
  logic           out_last_r, out_bad_r;
  logic           code_lit, parent_lit;

  assign code_lit   = cmd_r.code[lzwd_pkg::CODE_W-1] == 1'b0;
  assign parent_lit = parent_q[lzwd_pkg::CODE_W-1] == 1'b0;
  assign out_free   = !out_valid_r || pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzwd_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_data.err) state_nxt = lzwd_pkg::ST_ERR;
          else if (cmd_data.pre_wr) state_nxt = lzwd_pkg::ST_PRE;
          else state_nxt = lzwd_pkg::ST_ISSUE;
        end
      end
      lzwd_pkg::ST_PRE:   state_nxt = lzwd_pkg::ST_ISSUE;
      lzwd_pkg::ST_ISSUE: state_nxt = code_lit ? lzwd_pkg::ST_LIT : lzwd_pkg::ST_WALK;
      lzwd_pkg::ST_WALK:  if (parent_lit) state_nxt = lzwd_pkg::ST_LIT;
      lzwd_pkg::ST_LIT:   state_nxt = lzwd_pkg::ST_RD;
      lzwd_pkg::ST_RD:    state_nxt = lzwd_pkg::ST_AP;
      lzwd_pkg::ST_AP: begin
        if (cnt_r == 4'd7 || sp_r == '0) state_nxt = lzwd_pkg::ST_OUT;
      end
      lzwd_pkg::ST_OUT: begin
        if (out_free) state_nxt = (sp_r == '0) ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_RD;
      end
      lzwd_pkg::ST_ERR:   if (out_free) state_nxt = lzwd_pkg::ST_IDLE;
      default:            state_nxt = lzwd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    cmd_nxt        = cmd_r;
    n_nxt          = n_r;
    sp_nxt         = sp_r;
    cnt_nxt        = cnt_r;
    asm_nxt        = asm_r;
    lit_nxt        = lit_r;
    prev_first_nxt = prev_first_r;
    dict_rd_addr   = parent_q[IW-1:0];
    dict_wr        = 1'b0;
    dict_wr_addr   = cmd_r.wr_idx[IW-1:0];
    dict_wr_parent = cmd_r.parent;
    dict_wr_byte   = lit_r;
    stack_wr       = 1'b0;
    stack_wr_byte  = lit_r;
    stack_rd_addr  = sp_r - SAW'(1);
    out_load       = 1'b0;
    out_bad_in     = 1'b0;
    out_last_in    = 1'b1;
    unique case (state_r)
      lzwd_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_data;
          n_nxt   = '0;
          cnt_nxt = '0;
          asm_nxt = '0;
        end
      end
      lzwd_pkg::ST_PRE: begin
        dict_wr      = 1'b1;
        dict_wr_byte = prev_first_r;
      end
      lzwd_pkg::ST_ISSUE: begin
        dict_rd_addr = cmd_r.code[IW-1:0];
        lit_nxt      = cmd_r.code[7:0] & lzwd_pkg::BYTE_MASK;
      end
      lzwd_pkg::ST_WALK: begin
        stack_wr      = 1'b1;
        stack_wr_byte = suffix_q;
        n_nxt         = n_r + SAW'(1);
        lit_nxt       = parent_q[7:0] & lzwd_pkg::BYTE_MASK;
      end
      lzwd_pkg::ST_LIT: begin
        stack_wr       = 1'b1;
        n_nxt          = n_r + SAW'(1);
        sp_nxt         = n_r + SAW'(1);
        prev_first_nxt = lit_r;
        dict_wr        = cmd_r.post_wr;
      end
      lzwd_pkg::ST_RD: begin
        sp_nxt = sp_r - SAW'(1);
      end
      lzwd_pkg::ST_AP: begin
        asm_nxt[cnt_r[2:0]*8 +: 8] = stack_q;
        cnt_nxt                    = cnt_r + 4'd1;
        if (!(cnt_r == 4'd7 || sp_r == '0)) begin
          sp_nxt = sp_r - SAW'(1);
        end
      end
      lzwd_pkg::ST_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_last_in = sp_r == '0;
          asm_nxt     = '0;
          cnt_nxt     = '0;
        end
      end
      lzwd_pkg::ST_ERR: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_bad_in = 1'b1;
          asm_nxt    = '0;
          cnt_nxt    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    parent_q <= parent_mem[dict_rd_addr];
    suffix_q <= suffix_mem[dict_rd_addr];
    if (dict_wr) begin
      parent_mem[dict_wr_addr] <= dict_wr_parent;
      suffix_mem[dict_wr_addr] <= dict_wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    stack_q <= stack_mem[stack_rd_addr];
    if (stack_wr) begin
      stack_mem[n_r] <= stack_wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    n_r          <= n_nxt;
    sp_r         <= sp_nxt;
    cnt_r        <= cnt_nxt;
    asm_r        <= asm_nxt;
    lit_r        <= lit_nxt;
    if (out_load) begin
      out_bytes_r <= asm_r;
      out_count_r <= cnt_r;
      out_last_r  <= out_last_in;
      out_bad_r   <= out_bad_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzwd_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      prev_first_r <= '0;
    end else begin
      state_r      <= state_nxt;
      prev_first_r <= prev_first_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign empty          = !out_valid_r;
  assign out_bytes_out  = out_bytes_r;
  assign out_byte_count = out_count_r;
  assign out_last       = out_last_r;
  assign out_bad_code   = out_bad_r;

endmodule
`default_nettype wire

// File: hw/rtl/lzw_decoder_top.sv
// ----------------------------------------------------------------------------
// LZW decoder top level
// A code not yet in the dictionary first writes its entry; the chain is walked
// onto a byte stack with one dictionary read per cycle, and the stack is packed
// one byte per cycle into results of up to eight bytes, pausing while a result
// waits for the receiver. Up to two codes queue while the back end decodes.
// Reset: synchronous, active low; dictionary contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module lzw_decoder_top #(
  parameter int DICT_CODES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [8:0]  in_code,
  input  wire logic        in_restart,
  input  wire logic        pop,
  output logic             empty,
  output logic [63:0]      out_bytes_out,
  output logic [3:0]       out_byte_count,
  output logic             out_last,
  output logic             out_bad_code
);

  localparam int CAP   = (DICT_CODES < 512) ? DICT_CODES : 512;
  localparam int STORE = CAP - 256;
  localparam int IW    = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int NW    = $clog2(DICT_CODES + 1);

  lzwd_pkg::cmd_t wr_cmd, rd_cmd;
  logic           cmd_push, cmd_full, cmd_pop, cmd_empty;

  lzwd_front #(.DICT_CODES(DICT_CODES), .NW(NW), .CAP(CAP)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_code   (in_code),
    .in_restart(in_restart),
    .cmd_push  (cmd_push),
    .cmd_data  (wr_cmd),
    .cmd_full  (cmd_full)
  );

  lzwd_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cmd_push),
    .wr_data   (wr_cmd),
    .fifo_full (cmd_full),
    .rd_en     (cmd_pop),
    .rd_data   (rd_cmd),
    .fifo_empty(cmd_empty)
  );

  lzwd_back #(.STORE(STORE), .IW(IW)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_data      (rd_cmd),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .pop           (pop),
    .empty         (empty),
    .out_bytes_out (out_bytes_out),
    .out_byte_count(out_byte_count),
    .out_last      (out_last),
    .out_bad_code  (out_bad_code)
  );

endmodule
`default_nettype wire

// File: hw/rtl/lzwd_checker.sv
// ----------------------------------------------------------------------------
// LZW decoder port checker
// Checks the form of result transactions seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module lzwd_port_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [3:0]  out_byte_count,
  input wire logic        out_last,
  input wire logic        out_bad_code
);

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_bad_code) |-> (out_byte_count == 4'd0 && out_last))
    else $error("Error result must be empty and final.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_bad_code) |-> (out_byte_count != 4'd0 && out_byte_count <= 4'd8))
    else $error("Data result byte count out of range.");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_byte_count == 4'd8))
    else $error("Non-final result must carry eight bytes.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("Pending result transaction was dropped.");

endmodule

bind lzw_decoder_top lzwd_port_props u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .pop           (pop),
  .empty         (empty),
  .out_byte_count(out_byte_count),
  .out_last      (out_last),
  .out_bad_code  (out_bad_code)
);
`default_nettype wire

// File: test/lzwd_checker.sv
// ----------------------------------------------------------------------------
// LZW decoder checker
// Watches both queue channels, predicts the decoded byte groups of every
// accepted code and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module lzwd_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [8:0]  in_code,
  input  wire logic        in_restart,
  input  wire logic        pop,
  input  wire logic        empty,
  input  wire logic [63:0] out_bytes_out,
  input  wire logic [3:0]  out_byte_count,
  input  wire logic        out_last,
  input  wire logic        out_bad_code,
  output int               n_fail,
  output int               n_pending,
  output int               n_results,
  output int               n_bad
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DICT_CODES = 512;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic        bad;
  } group_t;

  group_t      group_q[$];
  logic [8:0]  dict_parent[256];
  logic [7:0]  dict_suffix[256];
  logic [7:0]  chain[257];
  logic [8:0]  prev_code;
  logic [7:0]  prev_first;
  logic [9:0]  next_free;
  logic        have_prev;

  function automatic void enqueue_group(group_t g);
    group_q.insert(group_q.size(), g);
  endfunction

  function automatic int walk_chain(logic [8:0] c);
    int n;
    n = 0;
    while (c >= 256 && n < 256) begin
      chain[n] = dict_suffix[c - 256];
      c = dict_parent[c - 256];
      n++;
    end
    chain[n] = c[7:0];
    return n + 1;
  endfunction

  task automatic decode_code(logic [8:0] code, logic restart);
    int n, i, k;
    group_t g;
    logic [7:0] first;
    if (restart) begin
      next_free = 256;
      have_prev = 1'b0;
    end
    if (!have_prev) begin
      if (code >= 256) begin
        g = '{64'd0, 4'd0, 1'b1, 1'b1};
        enqueue_group(g);
        return;
      end
    end else if (code < next_free) begin
      n = walk_chain(code);
      if (next_free < DICT_CODES) begin
        dict_parent[next_free - 256] = prev_code;
        dict_suffix[next_free - 256] = chain[n - 1];
        next_free++;
      end
    end else if (code == next_free && next_free < DICT_CODES) begin
      dict_parent[next_free - 256] = prev_code;
      dict_suffix[next_free - 256] = prev_first;
      next_free++;
    end else begin
      g = '{64'd0, 4'd0, 1'b1, 1'b1};
      enqueue_group(g);
      return;
    end
    n = walk_chain(code);
    first = chain[n - 1];
    prev_code = code;
    prev_first = first;
    have_prev = 1'b1;
    i = 0;
    while (i < n) begin
      g = '{64'd0, 4'd0, 1'b0, 1'b0};
      for (k = 0; k < 8 && i < n; k++) begin
        g.bytes[8*k +: 8] = chain[n - 1 - i];
        g.cnt++;
        i++;
      end
      g.last = (i >= n);
      enqueue_group(g);
    end
  endtask

  initial begin
    n_fail = 0;
    n_results = 0;
    n_bad = 0;
    prev_code = '0;
    prev_first = '0;
    next_free = 256;
    have_prev = 1'b0;
  end

  assign n_pending = group_q.size();

  always @(posedge clk) begin
    group_t g;
    if (rst_n && push && !full) begin
      decode_code(in_code, in_restart);
    end
    if (rst_n && pop && !empty) begin
      n_results++;
      if (out_bad_code) begin
        n_bad++;
      end
      if (group_q.size() == 0) begin
        $error("result transaction with no prediction waiting");
        n_fail++;
      end else begin
        g = group_q.pop_front();
        if (out_bytes_out !== g.bytes) begin
          $error("bytes_out: expected %h, actual %h", g.bytes, out_bytes_out);
          n_fail++;
        end
        if (out_byte_count !== g.cnt) begin
          $error("byte_count: expected %0d, actual %0d", g.cnt, out_byte_count);
          n_fail++;
        end
        if (out_last !== g.last) begin
          $error("last: expected %0d, actual %0d", g.last, out_last);
          n_fail++;
        end
        if (out_bad_code !== g.bad) begin
          $error("bad_code: expected %0d, actual %0d", g.bad, out_bad_code);
          n_fail++;
        end
      end
    end
  end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// LZW decoder testbench
// Feeds directed and random code streams, including a stream that grows one
// long chain, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [8:0]  in_code = '0;
  logic        in_restart = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty, out_last, out_bad_code;
  logic [63:0] out_bytes_out;
  logic [3:0]  out_byte_count;
  int          n_fail, n_pending, n_results, n_bad;
  int          n_items = 0;
  int          idle_cycles = 0;
  bit          hold_req = 1'b0;
  logic [9:0]  free_code = 256;
  bit          started = 1'b0;

  always #5 clk = ~clk;

  lzw_decoder_top uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_code(in_code), .in_restart(in_restart),
    .pop(pop), .empty(empty), .out_bytes_out(out_bytes_out),
    .out_byte_count(out_byte_count), .out_last(out_last),
    .out_bad_code(out_bad_code)
  );

  lzwd_checker u_chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_code(in_code), .in_restart(in_restart),
    .pop(pop), .empty(empty), .out_bytes_out(out_bytes_out),
    .out_byte_count(out_byte_count), .out_last(out_last),
    .out_bad_code(out_bad_code), .n_fail(n_fail), .n_pending(n_pending),
    .n_results(n_results), .n_bad(n_bad)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_code(logic [8:0] code, logic restart);
    int g;
    push <= 1'b1;
    in_code <= code;
    in_restart <= restart;
    do @(posedge clk); while (full);
    n_items++;
    if (restart) begin
      free_code = 256;
      started = 1'b0;
    end
    if (!started) begin
      started = (code < 256);
    end else if (code < free_code || (code == free_code && free_code < 512)) begin
      if (free_code < 512) free_code++;
    end
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [8:0] valid_code();
    int r;
    r = $urandom_range(0, 9);
    if (!started || free_code == 256 || r < 3) return 9'($urandom_range(0, 255));
    if (r < 5 && free_code < 512) return free_code[8:0];
    return 9'($urandom_range(256, free_code - 1));
  endfunction

  always begin
    @(posedge clk);
    if (hold_req) begin
      pop <= 1'b0;
      repeat (3000) @(posedge clk);
      hold_req = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end else begin
      pop <= 1'b1;
      repeat ($urandom_range(0, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int k, r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first code after reset without restart, literal extremes,
    // a non-literal first code, codes ahead of the dictionary, and the
    // not-yet-defined code.
    send_code(9'd300, 1'b0);
    send_code(9'd0, 1'b0);
    send_code(9'd255, 1'b0);
    send_code(9'd256, 1'b0);
    send_code(9'd258, 1'b0);
    send_code(9'd511, 1'b0);
    send_code(9'd257, 1'b0);
    send_code(9'd259, 1'b0);
    send_code(9'd256, 1'b1);
    send_code(9'd170, 1'b1);
    send_code(9'd85, 1'b0);
    send_code(9'd256, 1'b0);
    send_code(9'd258, 1'b0);
    send_code(9'd260, 1'b0);
    send_code(9'd511, 1'b0);

    // One chain grows long; the receiver holds off a while.
    send_code(9'd65, 1'b1);
    hold_req = 1'b1;
    for (k = 0; k < 40; k++) send_code(free_code[8:0], 1'b0);
    send_code(9'd511, 1'b0);
    send_code(9'd300, 1'b0);
    send_code(9'd7, 1'b0);

    for (k = 0; k < 70; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_code(9'($urandom_range(0, 511)), 1'b1);
      else if (r < 8) send_code(9'($urandom_range(0, 511)), 1'b0);
      else if (r < 11) send_code(9'($urandom_range(0, 255)), 1'b1);
      else send_code(valid_code(), 1'b0);
    end
    push <= 1'b0;

    while (n_pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d codes and checked %0d result transactions (%0d error results),",
             n_items, n_results, n_bad);
    $display("covering restarts, undefined codes and long chains.");
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_front.sv
hw/rtl/lzwd_cmd_fifo.sv
hw/rtl/lzwd_back.sv
hw/rtl/lzw_decoder_top.sv
hw/rtl/lzwd_checker.sv
test/lzwd_checker.sv
test/tb_top.sv
